FILE: hdl/wft_pkg.sv
// Shared types and constants for the word frequency table.
`timescale 1ns / 1ps
`default_nettype none

package wft_pkg;

    localparam int SLOTS       = 24;
    localparam int LETTER_BITS = 5;
    localparam int WORD_BITS   = SLOTS * LETTER_BITS;
    localparam int HALF_SLOTS  = 12;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic word_add;
        logic scan_start;
        logic scan_rd;
        logic pos_inc;
        logic cnt_write;
        logic set_ovf;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic ins_write;
        logic word_clear;
        logic rank_rd;
        logic out_load;
    } wft_cmd_t;

    typedef struct packed {
        logic is_letter;
        logic in_word;
        logic pos_at_total;
        logic cmp_lt;
        logic cmp_eq;
        logic full;
        logic k_at_pos;
        logic out_free;
    } wft_sts_t;

endpackage

`default_nettype wire

FILE: hdl/wft_ctrl.sv
// Controller state machine for the word frequency table.
`timescale 1ns / 1ps
`default_nettype none

module wft_ctrl
    import wft_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_func,
    output logic          in_ready,
    input  wft_sts_t      sts,
    output wft_cmd_t      cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SCAN_CHK  = 8'b0000_0010,
        ST_SCAN_CMP  = 8'b0000_0100,
        ST_DECIDE    = 8'b0000_1000,
        ST_SHIFT_CHK = 8'b0001_0000,
        ST_SHIFT_WR  = 8'b0010_0000,
        ST_INSERT    = 8'b0100_0000,
        ST_READ_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_READ)
                    begin
                        cmd.rank_rd = 1'b1;
                        state_next  = ST_READ_OUT;
                    end
                    else if (sts.is_letter)
                    begin
                        cmd.word_add = 1'b1;
                    end
                    else if (sts.in_word)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN_CHK;
                    end
                end
            end
            ST_SCAN_CHK:
            begin
                if (sts.pos_at_total)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (sts.cmp_lt)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
                else if (sts.cmp_eq)
                begin
                    cmd.cnt_write  = 1'b1;
                    cmd.word_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.full)
                begin
                    cmd.set_ovf    = 1'b1;
                    cmd.word_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_CHK;
                end
            end
            ST_SHIFT_CHK:
            begin
                if (sts.k_at_pos)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_CHK;
            end
            ST_INSERT:
            begin
                cmd.ins_write  = 1'b1;
                cmd.word_clear = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_READ_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/wft_datapath.sv
// Datapath of the word frequency table: current word, sorted table memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module wft_datapath
    import wft_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_LETTERS = 24,
    parameter int COUNT_BITS  = 20
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    text_byte,
    input  wire logic [9:0]    entry_rank,
    input  wft_cmd_t           cmd,
    output wft_sts_t           sts,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [159:0]       out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = WORD_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [EW-1:0] mem [TABLE_DEPTH];

    logic [WORD_BITS-1:0]   cur_word_reg, cur_word_next;
    logic [4:0]             cur_len_reg, cur_len_next;
    logic                   in_word_reg, in_word_next;
    logic                   trunc_reg, trunc_next;
    logic                   ovf_reg, ovf_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          pos_reg, pos_next;
    logic [TW-1:0]          k_reg, k_next;
    logic [9:0]             rank_reg;
    logic [EW-1:0]          rdata_reg;
    logic                   out_valid_reg;
    logic [159:0]           out_data_reg;

    logic [LETTER_BITS-1:0] code;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic                   wr_en;
    logic [TW-1:0]          k_dec;
    logic [WORD_BITS-1:0]   stored_word;
    logic [COUNT_BITS-1:0]  stored_count;
    logic [59:0]            first_w, rest_w;
    logic [4:0]             len_w;
    logic                   present;

    always_comb
    begin
        code = '0;
        if (text_byte >= UPPER_A && text_byte <= UPPER_Z)
        begin
            code = LETTER_BITS'(text_byte - UPPER_A + 8'd1);
        end
        else if (text_byte >= LOWER_A && text_byte <= LOWER_Z)
        begin
            code = LETTER_BITS'(text_byte - LOWER_A + 8'd1);
        end
    end

    assign stored_word  = rdata_reg[WORD_BITS-1:0];
    assign stored_count = rdata_reg[EW-1:WORD_BITS];
    assign k_dec        = k_reg - TW'(1);

    assign sts.is_letter    = (code != '0);
    assign sts.in_word      = in_word_reg;
    assign sts.pos_at_total = (pos_reg == total_reg);
    assign sts.cmp_lt       = (stored_word < cur_word_reg);
    assign sts.cmp_eq       = (stored_word == cur_word_reg);
    assign sts.full         = (32'(total_reg) == 32'(TABLE_DEPTH));
    assign sts.k_at_pos     = (k_reg == pos_reg);
    assign sts.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        cur_word_next = cur_word_reg;
        cur_len_next  = cur_len_reg;
        in_word_next  = in_word_reg;
        trunc_next    = trunc_reg;
        ovf_next      = ovf_reg;
        total_next    = total_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        if (cmd.word_add)
        begin
            in_word_next = 1'b1;
            if (32'(cur_len_reg) < 32'(MAX_LETTERS))
            begin
                cur_word_next[(SLOTS - 1 - 32'(cur_len_reg)) * LETTER_BITS +: LETTER_BITS] = code;
                cur_len_next = cur_len_reg + 5'd1;
            end
            else
            begin
                trunc_next = 1'b1;
            end
        end
        if (cmd.scan_start)
        begin
            pos_next = '0;
        end
        if (cmd.pos_inc)
        begin
            pos_next = pos_reg + TW'(1);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.shift_init)
        begin
            k_next = total_reg;
        end
        if (cmd.shift_wr)
        begin
            k_next = k_dec;
        end
        if (cmd.ins_write)
        begin
            total_next = total_reg + TW'(1);
        end
        if (cmd.word_clear)
        begin
            cur_word_next = '0;
            cur_len_next  = '0;
            in_word_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_word_reg  <= '0;
            cur_len_reg   <= '0;
            in_word_reg   <= 1'b0;
            trunc_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_word_reg <= cur_word_next;
            cur_len_reg  <= cur_len_next;
            in_word_reg  <= in_word_next;
            trunc_reg    <= trunc_next;
            ovf_reg      <= ovf_next;
            total_reg    <= total_next;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        rd_en   = cmd.rank_rd || cmd.scan_rd || cmd.shift_rd;
        rd_addr = pos_reg[AW-1:0];
        if (cmd.rank_rd)
        begin
            rd_addr = AW'(entry_rank);
        end
        else if (cmd.shift_rd)
        begin
            rd_addr = k_dec[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = cmd.cnt_write || cmd.shift_wr || cmd.ins_write;
        wr_addr = pos_reg[AW-1:0];
        wr_data = {COUNT_BITS'(1), cur_word_reg};
        if (cmd.cnt_write)
        begin
            wr_data = {(stored_count == COUNT_MAX) ? stored_count
                                                   : stored_count + COUNT_BITS'(1),
                       stored_word};
        end
        else if (cmd.shift_wr)
        begin
            wr_addr = k_reg[AW-1:0];
            wr_data = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.rank_rd)
        begin
            rank_reg <= entry_rank;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {1'b0, trunc_reg, ovf_reg, 11'(total_reg),
                             present ? 20'(stored_count) : 20'd0,
                             present ? len_w : 5'd0,
                             present ? rest_w : 60'd0,
                             present ? first_w : 60'd0,
                             present};
        end
    end

    always_comb
    begin
        first_w = '0;
        rest_w  = '0;
        len_w   = '0;
        for (int i = 0; i < HALF_SLOTS; i++)
        begin
            first_w[i*LETTER_BITS +: LETTER_BITS] =
                stored_word[(SLOTS - 1 - i) * LETTER_BITS +: LETTER_BITS];
            rest_w[i*LETTER_BITS +: LETTER_BITS] =
                stored_word[(HALF_SLOTS - 1 - i) * LETTER_BITS +: LETTER_BITS];
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            len_w = len_w + 5'(stored_word[i*LETTER_BITS +: LETTER_BITS] != '0);
        end
    end

    assign present   = (32'(rank_reg) < 32'(total_reg));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/word_frequency_table.sv
// Top level of the word frequency table.
// The slave stream carries one text byte or one read request per transaction;
// tuser selects which (0 = text byte, 1 = read by alphabetical rank).
// Letters are folded to lower case and build the current word; any other byte
// ends the word, which is then counted in a table kept in alphabetical order.
// Only a read request produces a master transaction with the entry at that rank.
// A word end scans the table with one memory read per entry passed, then an
// insert moves each later entry with one read and one write; a new word that
// finds the table full is dropped and sets the overflow flag. The input is held
// off until the word end is done. A read loads the entry into the read data
// register, then into the output register once that register is free.
// The table memory has one read and one write port; its read data is registered.
// The result waits in an output register while the receiver stalls; text still
// flows, and a further read request is taken but then holds off the input until
// that register is free.
// Reset empties the table, clears the current word and the sticky flags.
`timescale 1ns / 1ps
`default_nettype none

module word_frequency_table
    import wft_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_LETTERS = 24,
    parameter int COUNT_BITS  = 20
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // text_byte, entry_rank, zero pad
    input  wire logic [0:0]   s_axis_tuser,   // func
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // entry_present, letters_first, letters_rest, letter_count, occurrences,
    // distinct_words, table_overflowed, word_truncated, zero pad
    output logic [159:0]      m_axis_tdata
);

    wft_cmd_t cmd;
    wft_sts_t sts;

    wft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wft_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_LETTERS (MAX_LETTERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (s_axis_tdata[7:0]),
        .entry_rank (s_axis_tdata[17:8]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire
